// ===== rtl/core/pws_pkg.sv =====
// Shared types and constants for the parallel work splitter.
// Used by the channel interfaces, the divider and the top level.
package pws_pkg;

  localparam int NUM_W      = 32;
  localparam int TASK_W     = 13;
  localparam int CNT_CFG_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_TASKS_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASKS_PER_WORKER = 2'd2;

  localparam logic [NUM_W-1:0]     BIN_SIZE_RST         = 32'd1;
  localparam logic [CNT_CFG_W-1:0] WORKER_COUNT_RST     = 7'd4;
  localparam logic [CNT_CFG_W-1:0] TASKS_PER_WORKER_RST = 7'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/pws_if.sv =====
// Request and result channel interfaces of the parallel work splitter.
// Depends on pws_pkg for the field widths.
interface pws_in_if;
  import pws_pkg::*;

  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] num_items;

  modport source (output valid, output num_items, input ready);
  modport sink   (input valid, input num_items, output ready);
endinterface

interface pws_out_if;
  import pws_pkg::*;

  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] task_count;
  logic [NUM_W-1:0]  items_per_task;
  logic              serial;

  modport source (output valid, output task_count, output items_per_task, output serial,
                  input ready);
  modport sink   (input valid, input task_count, input items_per_task, input serial,
                  output ready);
endinterface

// ===== rtl/core/pws_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pws_pkg for the operand width and the status struct.
module pws_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [pws_pkg::NUM_W-1:0] dividend,
  input  logic [pws_pkg::NUM_W-1:0] divisor,
  output logic [pws_pkg::NUM_W-1:0] quotient,
  output logic [pws_pkg::NUM_W-1:0] remainder,
  output pws_pkg::div_stat_t        stat
);
  import pws_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dvs_r;
  logic [NUM_W:0]   shifted;
  logic [NUM_W+1:0] trial;
  logic             neg;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign neg     = trial[NUM_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= neg ? shifted[NUM_W-1:0] : trial[NUM_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ~neg};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

// ===== rtl/core/parallel_work_splitter.sv =====
// Parallel work splitter: turns a job's item count into a task count and a
// number of items per task. Depends on pws_pkg, pws_if and pws_div.
//
// A job within the bin size skips the divider and goes straight to the done state.
// Any other job passes through one shared divider two or three times
// (count by bin size, count by task count, then one rounding-up division when
// the split by task count leaves a remainder).
// The request side is ready only while the sequencer is idle; a finished
// result waits in the output register and does not hold up the next request.
module parallel_work_splitter #(
  parameter int MAX_TASKS = pws_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pws_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pws_in_if.sink                         in_ch,
  pws_out_if.source                      out_ch
);
  import pws_pkg::*;

  localparam int TW = $clog2(MAX_TASKS + 2);
  localparam int PW = 2 * CNT_CFG_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WANT = 3'd1;
  localparam logic [2:0] S_PER  = 3'd2;
  localparam logic [2:0] S_ADJ  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r;
  logic [NUM_W-1:0]     bin_r;
  logic [CNT_CFG_W-1:0] wc_r;
  logic [CNT_CFG_W-1:0] tpw_r;
  logic [NUM_W-1:0]     n_r;
  logic [TW-1:0]        limit_r;
  logic [TW-1:0]        tasks_r;
  logic [NUM_W-1:0]     per_r;
  logic                 serial_r;
  logic                 ceil_per_r;

  logic                 out_valid_r;
  logic [TASK_W-1:0]    out_tasks_r;
  logic [NUM_W-1:0]     out_per_r;
  logic                 out_serial_r;

  logic                 accept;
  logic                 is_serial;
  logic [PW-1:0]        prod;
  logic [TW-1:0]        limit_nxt;
  logic [NUM_W-1:0]     bin_eff;
  logic [TW-1:0]        tasks_pick;
  logic [NUM_W-1:0]     ceil_q;
  logic [NUM_W-1:0]     tasks_ext;
  logic                 out_load;

  logic                 div_start;
  logic [NUM_W-1:0]     div_dividend;
  logic [NUM_W-1:0]     div_divisor;
  logic [NUM_W-1:0]     div_q;
  logic [NUM_W-1:0]     div_r;
  div_stat_t            div_stat;

  pws_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_serial   = (in_ch.num_items <= bin_r);
  assign bin_eff     = (bin_r == '0) ? NUM_W'(1) : bin_r;

  always_comb begin
    prod = {{CNT_CFG_W{1'b0}}, wc_r} * {{CNT_CFG_W{1'b0}}, tpw_r};
    if (32'(prod) > 32'(MAX_TASKS)) begin
      limit_nxt = TW'(MAX_TASKS);
    end else if (prod == '0) begin
      limit_nxt = TW'(1);
    end else begin
      limit_nxt = TW'(prod);
    end
  end

  always_comb begin
    if (div_q >= 32'(limit_r)) begin
      tasks_pick = limit_r;
    end else if (div_q == '0) begin
      tasks_pick = TW'(1);
    end else begin
      tasks_pick = TW'(div_q);
    end
  end

  assign ceil_q = div_q + ((div_r != '0) ? NUM_W'(1) : NUM_W'(0));

  always_comb begin
    div_start    = 1'b0;
    div_dividend = n_r;
    div_divisor  = bin_eff;
    case (state_r)
      S_IDLE: begin
        div_dividend = in_ch.num_items;
        div_start    = accept && !is_serial;
      end
      S_WANT: begin
        div_start   = div_stat.done;
        div_divisor = 32'(tasks_pick);
      end
      S_PER: begin
        div_start = div_stat.done && (div_r != '0);
        if (div_q >= div_r) begin
          div_divisor = 32'(tasks_r) + 32'd1;
        end else begin
          div_divisor = div_q + 32'd1;
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign tasks_ext = 32'(tasks_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= BIN_SIZE_RST;
      wc_r  <= WORKER_COUNT_RST;
      tpw_r <= TASKS_PER_WORKER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIN_SIZE:         bin_r <= cfg_wdata;
        CFG_WORKER_COUNT:     wc_r  <= cfg_wdata[CNT_CFG_W-1:0];
        CFG_TASKS_PER_WORKER: tpw_r <= cfg_wdata[CNT_CFG_W-1:0];
        default: begin
          bin_r <= bin_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= is_serial ? S_DONE : S_WANT;
          end
        end
        S_WANT: begin
          if (div_stat.done) begin
            state_r <= S_PER;
          end
        end
        S_PER: begin
          if (div_stat.done) begin
            state_r <= (div_r != '0) ? S_ADJ : S_DONE;
          end
        end
        S_ADJ: begin
          if (div_stat.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r      <= in_ch.num_items;
        per_r    <= in_ch.num_items;
        tasks_r  <= TW'(1);
        limit_r  <= limit_nxt;
        serial_r <= is_serial;
      end
      S_WANT: begin
        if (div_stat.done) begin
          tasks_r <= tasks_pick;
        end
      end
      S_PER: begin
        if (div_stat.done) begin
          per_r      <= div_q;
          ceil_per_r <= (div_q >= div_r);
          if (div_r != '0 && div_q >= div_r) begin
            tasks_r <= tasks_r + 1'b1;
          end
          if (div_r != '0 && div_q < div_r) begin
            per_r <= div_q + 32'd1;
          end
        end
      end
      S_ADJ: begin
        if (div_stat.done) begin
          if (ceil_per_r) begin
            per_r <= ceil_q;
          end else begin
            tasks_r <= TW'(ceil_q);
          end
        end
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tasks_r  <= tasks_ext[TASK_W-1:0];
      out_per_r    <= per_r;
      out_serial_r <= serial_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.task_count     = out_tasks_r;
  assign out_ch.items_per_task = out_per_r;
  assign out_ch.serial         = out_serial_r;

  // A serial job always reports exactly one task.
  a_serial_one_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.serial |-> out_ch.task_count == TASK_W'(1))
    else $error("serial result with a task count other than one");

  // The divider is never restarted while a division is in flight.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A division result only arrives while the sequencer waits for one.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_WANT || state_r == S_PER || state_r == S_ADJ))
    else $error("division finished outside a division state");

  // A taken request closes the request side until its result is loaded into the output register.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("request side ready right after a request was taken");

endmodule
